/* rtl/monotone_lower_envelope_core_defines.svh */
// assertion macros shared by the envelope core files
`ifndef MONOTONE_LOWER_ENVELOPE_CORE_DEFINES_SVH
`define MONOTONE_LOWER_ENVELOPE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
`define MLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define MLE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MLE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/mle_pkg.sv */
`timescale 1ns / 1ps
package mle_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int SLOPE_W   = 32;
  localparam int ICPT_W    = 64;
  localparam int X_W       = 32;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;
  localparam int LINES_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int MAG_W     = 64;
  localparam int DEN_W     = 33;
  localparam int PROD_W    = MAG_W + DEN_W;
  localparam int CNT_W     = $clog2(DEN_W + 1);
  localparam int LINE_W    = SLOPE_W + ICPT_W;

  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SLOPE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SENT_SLOPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENT_ICPT  = 2'd1;

  localparam logic signed [SLOPE_W-1:0] SENT_SLOPE_RESET = 32'sd1000000000;
  localparam logic signed [ICPT_W-1:0]  SENT_ICPT_RESET  = 64'sd0;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [SLOPE_W-1:0] line_slope;
    logic signed [ICPT_W-1:0]  line_intercept;
    logic signed [X_W-1:0]     query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [ICPT_W-1:0] value;
    logic [STAT_W-1:0]        status;
    logic [LINES_W-1:0]       lines_held;
  } out_item_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
  } line_t;

  // breakpoint: kind -1 minus infinity, 0 finite rational, +1 plus infinity
  typedef struct packed {
    logic signed [1:0] kind;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [DEN_W-1:0]  den;
  } bp_t;

  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_res_t;

  // crossing of upper line up with lower line lo, kept as exact fraction
  function automatic bp_t make_bp(line_t lo, line_t up);
    logic signed [SLOPE_W:0] d;
    logic signed [SLOPE_W:0] nd;
    logic signed [ICPT_W:0]  diff;
    logic signed [ICPT_W:0]  ndiff;
    bp_t r;
    d = {lo.slope[SLOPE_W-1], lo.slope} - {up.slope[SLOPE_W-1], up.slope};
    nd = -d;
    diff = {up.intercept[ICPT_W-1], up.intercept} - {lo.intercept[ICPT_W-1], lo.intercept};
    ndiff = -diff;
    r.neg = diff[ICPT_W];
    r.mag = diff[ICPT_W] ? ndiff[MAG_W-1:0] : diff[MAG_W-1:0];
    r.kind = 2'sd0;
    r.den = DEN_W'(1);
    if (d == '0) begin
      r.kind = (!r.neg && (r.mag != '0)) ? 2'sd1 : -2'sd1;
    end else if (d[SLOPE_W]) begin
      r.neg = !r.neg;
      r.den = nd;
    end else begin
      r.den = d;
    end
    if (r.mag == '0) r.neg = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/mle_ram.sv */
`timescale 1ns / 1ps
module mle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mle_cmp.sv */
`timescale 1ns / 1ps
`include "monotone_lower_envelope_core_defines.svh"
module mle_cmp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mle_pkg::bp_t      a,
  input  mle_pkg::bp_t      b,
  output logic              done,
  output mle_pkg::cmp_res_t res
);
  import mle_pkg::*;

  // two shift-add multipliers run side by side: a.mag*b.den and b.mag*a.den
  logic [PROD_W-1:0] acc1_r, acc2_r, mc1_r, mc2_r;
  logic [DEN_W-1:0]  mp1_r, mp2_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic signed [1:0] ka_r, kb_r;
  logic              na_r, nb_r;
  cmp_res_t          res_r, fin;
  logic              s1, s2;

  always_comb begin
    s1 = na_r && (acc1_r != '0);
    s2 = nb_r && (acc2_r != '0);
    fin.lt = 1'b0;
    fin.gt = 1'b0;
    if ((ka_r != 2'sd0) || (kb_r != 2'sd0)) begin
      fin.lt = ka_r < kb_r;
      fin.gt = ka_r > kb_r;
    end else if (s1 != s2) begin
      fin.lt = s1;
      fin.gt = !s1;
    end else if (s1) begin
      fin.lt = acc1_r > acc2_r;
      fin.gt = acc1_r < acc2_r;
    end else begin
      fin.lt = acc1_r < acc2_r;
      fin.gt = acc1_r > acc2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      acc1_r <= '0;
      acc2_r <= '0;
      mc1_r  <= '0;
      mc2_r  <= '0;
      mp1_r  <= '0;
      mp2_r  <= '0;
      ka_r   <= 2'sd0;
      kb_r   <= 2'sd0;
      na_r   <= 1'b0;
      nb_r   <= 1'b0;
      res_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= CNT_W'(DEN_W);
          acc1_r <= '0;
          acc2_r <= '0;
          mc1_r  <= PROD_W'(a.mag);
          mc2_r  <= PROD_W'(b.mag);
          mp1_r  <= b.den;
          mp2_r  <= a.den;
          ka_r   <= a.kind;
          kb_r   <= b.kind;
          na_r   <= a.neg;
          nb_r   <= b.neg;
        end
      end else if (cnt_r != '0) begin
        if (mp1_r[0]) acc1_r <= acc1_r + mc1_r;
        if (mp2_r[0]) acc2_r <= acc2_r + mc2_r;
        mc1_r <= mc1_r << 1;
        mc2_r <= mc2_r << 1;
        mp1_r <= mp1_r >> 1;
        mp2_r <= mp2_r >> 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end else begin
        res_r  <= fin;
        done_r <= 1'b1;
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

  `MLE_ASSERT_IMP(a_cmp_no_restart, clk, rst_n, start, !busy_r)
  `MLE_ASSERT_IMP(a_cmp_done_idle, clk, rst_n, done_r, !busy_r)
  `MLE_ASSERT_IMP(a_cmp_not_both, clk, rst_n, 1'b1, !(res_r.lt && res_r.gt))

endmodule

/* rtl/monotone_lower_envelope_core.sv */
`timescale 1ns / 1ps
// Lower envelope of lines with strictly decreasing slopes (convex hull trick).
// func 0 returns the envelope value at query_x, func 1 pushes a line after
// popping the lines it hides, func 2 restores the two-line start hull (the
// sentinel from the cfg registers plus the line 0,0). Sentinel writes take
// effect at the next clear. Breakpoints are compared exactly by
// cross-multiplication in one shared bit-serial shift-add compare unit; the
// item time grows with the number of stack entries visited (query walks down
// from the top until a breakpoint lies at or left of x; insert walks down
// until the new line stops hiding the top). Slope rejects and clears skip
// the compare unit and finish without a stack walk.
// The stack sits in a one-write, one-read RAM; entry 0 and the initial zero
// line live in flops, so no clearing pass follows reset.
`include "monotone_lower_envelope_core_defines.svh"
module monotone_lower_envelope_core #(
  parameter int STACK_DEPTH = mle_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mle_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mle_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mle_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mle_pkg::*;

  localparam int IDX_W = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RD, S_LD, S_BP, S_CMP, S_MUL, S_ADD, S_PUSH, S_DONE
  } state_t;

  state_t              state_r;
  in_item_t            item_r;
  logic [IDX_W-1:0]    top_r, idx_r, rd_idx_r;
  line_t               upper_r, lower_r, top_line_r, sent_line_r, new_line, ram_line;
  logic signed [SLOPE_W-1:0] cfg_slope_r;
  logic signed [ICPT_W-1:0]  cfg_icpt_r;
  logic                e1_zero_r;      // entry 1 still holds the initial zero line
  logic signed [ICPT_W-1:0]  prod_r, value_r, mul_w;
  logic [STAT_W-1:0]   status_r;
  logic                out_valid_r;
  out_item_t           out_r;

  // memory port
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [LINE_W-1:0]   ram_q;

  // compare unit
  logic                cmp_start, cmp_done;
  bp_t                 cmp_a, cmp_b, q_bp;
  cmp_res_t            cmp_res;

  assign new_line.slope     = item_r.line_slope;
  assign new_line.intercept = item_r.line_intercept;
  assign ram_line           = line_t'(ram_q);

  // query point as a fraction x/1
  always_comb begin
    q_bp.kind = 2'sd0;
    q_bp.neg  = item_r.query_x[X_W-1];
    q_bp.mag  = item_r.query_x[X_W-1] ? MAG_W'(-{{(MAG_W-X_W){1'b1}}, item_r.query_x})
                                      : MAG_W'(item_r.query_x);
    q_bp.den  = DEN_W'(1);
  end

  assign cmp_a     = make_bp(lower_r, upper_r);
  assign cmp_b     = (item_r.func == FUNC_QUERY) ? q_bp : make_bp(lower_r, new_line);
  assign cmp_start = (state_r == S_BP);

  // read the line below the current one
  assign ram_re    = (state_r == S_RD) && (idx_r != '0);
  assign ram_raddr = idx_r - IDX_W'(1);
  assign ram_we    = (state_r == S_PUSH) && (idx_r != IDX_W'(STACK_DEPTH - 1));
  assign ram_waddr = idx_r + IDX_W'(1);

  // signed 32x32 product, sign-extended operands
  assign mul_w = ICPT_W'(upper_r.slope) * ICPT_W'(item_r.query_x);

  mle_ram #(
    .WIDTH (LINE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (LINE_W'(new_line)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  mle_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmp_start),
    .a     (cmp_a),
    .b     (cmp_b),
    .done  (cmp_done),
    .res   (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      item_r            <= '0;
      top_r             <= IDX_W'(1);
      idx_r             <= '0;
      rd_idx_r          <= '0;
      upper_r           <= '0;
      lower_r           <= '0;
      top_line_r        <= '0;
      sent_line_r.slope <= SENT_SLOPE_RESET;
      sent_line_r.intercept <= SENT_ICPT_RESET;
      cfg_slope_r       <= SENT_SLOPE_RESET;
      cfg_icpt_r        <= SENT_ICPT_RESET;
      e1_zero_r         <= 1'b1;
      prod_r            <= '0;
      value_r           <= '0;
      status_r          <= STAT_OK;
      out_valid_r       <= 1'b0;
      out_r             <= '0;
    end else begin
      // sentinel registers, applied at the next clear
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SENT_SLOPE: cfg_slope_r <= cfg_data[SLOPE_W-1:0];
          CFG_SENT_ICPT:  cfg_icpt_r  <= cfg_data;
          default: ;
        endcase
      end

      // result taken and no new one this cycle
      if (out_valid_r && out_ready && (state_r != S_DONE)) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          value_r  <= '0;
          idx_r    <= top_r;
          upper_r  <= top_line_r;
          if ((item_r.func == FUNC_INSERT) && (item_r.line_slope >= top_line_r.slope)) begin
            status_r <= STAT_SLOPE;
          end else begin
            status_r <= STAT_OK;
          end
          unique case (item_r.func)
            FUNC_QUERY: state_r <= S_RD;
            FUNC_INSERT: begin
              if (item_r.line_slope >= top_line_r.slope) begin
                state_r  <= S_DONE;
              end else begin
                state_r <= S_RD;
              end
            end
            FUNC_CLEAR: begin
              top_r                 <= IDX_W'(1);
              top_line_r            <= '0;
              e1_zero_r             <= 1'b1;
              sent_line_r.slope     <= cfg_slope_r;
              sent_line_r.intercept <= cfg_icpt_r;
              state_r               <= S_DONE;
            end
            default: state_r <= S_DONE;    // unused code: no effect
          endcase
        end
        S_RD: begin
          rd_idx_r <= ram_raddr;
          if (idx_r == '0) begin
            // bottom reached: sentinel answers the query, insert lands at 1
            state_r <= (item_r.func == FUNC_QUERY) ? S_MUL : S_PUSH;
          end else begin
            state_r <= S_LD;
          end
        end
        S_LD: begin
          if (rd_idx_r == '0) begin
            lower_r <= sent_line_r;
          end else if ((rd_idx_r == IDX_W'(1)) && e1_zero_r) begin
            lower_r <= '0;
          end else begin
            lower_r <= ram_line;
          end
          state_r <= S_BP;
        end
        S_BP: state_r <= S_CMP;
        S_CMP: begin
          if (cmp_done) begin
            if (item_r.func == FUNC_QUERY) begin
              // breakpoint at or left of x: upper line wins
              if (!cmp_res.gt) begin
                state_r <= S_MUL;
              end else begin
                upper_r <= lower_r;
                idx_r   <= idx_r - IDX_W'(1);
                state_r <= S_RD;
              end
            end else begin
              // new line hides the current top: pop it
              if (!cmp_res.lt) begin
                upper_r <= lower_r;
                idx_r   <= idx_r - IDX_W'(1);
                state_r <= S_RD;
              end else begin
                state_r <= S_PUSH;
              end
            end
          end
        end
        S_MUL: begin
          prod_r  <= mul_w;
          state_r <= S_ADD;
        end
        S_ADD: begin
          value_r <= prod_r + upper_r.intercept;
          state_r <= S_DONE;
        end
        S_PUSH: begin
          if (idx_r == IDX_W'(STACK_DEPTH - 1)) begin
            status_r <= STAT_FULL;
          end else begin
            top_r      <= ram_waddr;
            top_line_r <= new_line;
            if (idx_r == '0) e1_zero_r <= 1'b0;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          // result register: load once the previous transfer has gone
          if (!out_valid_r || out_ready) begin
            out_r.value      <= value_r;
            out_r.status     <= status_r;
            out_r.lines_held <= LINES_W'(top_r);
            out_valid_r      <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // top of stack never drops onto the sentinel
  `MLE_ASSERT_IMP(a_top_nonzero, clk, rst_n, 1'b1, top_r != '0)
  // the sentinel slot is never written in memory
  `MLE_ASSERT_IMP(a_no_write_slot0, clk, rst_n, ram_we, ram_waddr != '0)
  // an accepted item closes the input until it is finished
  `MLE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

/* dv/envelope_checker.sv */
`timescale 1ns / 1ps
module envelope_checker
  import mle_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen
);

  // exact crossing point num/den, or an infinity when kind is nonzero
  typedef struct {
    int                 kind;
    logic signed [66:0] num;
    logic signed [66:0] den;
  } crossing_t;

  longint    sent_slope;
  longint    sent_icpt;
  longint    hull_slope [DEPTH];
  longint    hull_icpt  [DEPTH];
  int        hull_top;
  out_item_t expected_results [$];

  function automatic crossing_t crossing(longint m0, longint b0, longint m1, longint b1);
    logic signed [66:0] e0;
    logic signed [66:0] e1;
    logic signed [66:0] dn;
    longint             dd;
    crossing_t          r;
    e0 = b0;
    e1 = b1;
    dn = e1 - e0;
    dd = m0 - m1;
    r.kind = 0;
    r.num = dn;
    r.den = 1;
    if (dd == 0) begin
      r.kind = (dn > 0) ? 1 : -1;
      r.num = 0;
    end else if (dd < 0) begin
      r.num = -dn;
      r.den = -dd;
    end else begin
      r.den = dd;
    end
    return r;
  endfunction

  function automatic int cmp_crossing(crossing_t a, crossing_t b);
    logic signed [135:0] lhs;
    logic signed [135:0] rhs;
    if (a.kind != 0 || b.kind != 0) return (a.kind > b.kind) - (a.kind < b.kind);
    lhs = a.num;
    lhs = lhs * b.den;
    rhs = b.num;
    rhs = rhs * a.den;
    return (lhs > rhs) - (lhs < rhs);
  endfunction

  function automatic crossing_t hull_crossing(int i);
    return crossing(hull_slope[i-1], hull_icpt[i-1], hull_slope[i], hull_icpt[i]);
  endfunction

  function automatic void reset_hull();
    hull_slope[0] = sent_slope;
    hull_icpt[0]  = sent_icpt;
    hull_slope[1] = 0;
    hull_icpt[1]  = 0;
    hull_top = 1;
  endfunction

  function automatic out_item_t envelope_step(in_item_t it);
    out_item_t r;
    crossing_t q;
    longint    x;
    longint    s;
    longint    c;
    int        up;
    int        t;
    r = '0;
    case (it.func)
      FUNC_QUERY: begin
        x = it.query_x;
        q.kind = 0;
        q.num = x;
        q.den = 1;
        up = 0;
        for (int i = 1; i <= hull_top; i++)
          if (cmp_crossing(hull_crossing(i), q) <= 0) up = i;
        r.value = hull_slope[up] * x + hull_icpt[up];
      end
      FUNC_INSERT: begin
        s = it.line_slope;
        c = it.line_intercept;
        if (s >= hull_slope[hull_top]) begin
          r.status = STAT_SLOPE;
        end else begin
          t = hull_top;
          while (t > 0 && cmp_crossing(hull_crossing(t),
                 crossing(hull_slope[t-1], hull_icpt[t-1], s, c)) >= 0)
            t--;
          if (t + 1 >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            t++;
            hull_slope[t] = s;
            hull_icpt[t] = c;
            hull_top = t;
          end
        end
      end
      FUNC_CLEAR: reset_hull();
      default: ;
    endcase
    r.lines_held = LINES_W'(hull_top);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at %0t: got %0d expected %0d", what, $time, got, want);
    fail_count++;
  endtask

  assign pending = expected_results.size();

  initial begin
    fail_count = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      sent_slope = SENT_SLOPE_RESET;
      sent_icpt  = SENT_ICPT_RESET;
      reset_hull();
      expected_results.delete();
    end else begin
      // register writes only matter at the next clear
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SENT_SLOPE) sent_slope = signed'(cfg_data[SLOPE_W-1:0]);
        else if (cfg_index == CFG_SENT_ICPT) sent_icpt = signed'(cfg_data);
      end
      if (in_valid && in_ready)
        expected_results = {expected_results, envelope_step(in_data)};
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data.value, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.value !== want.value)
            report_mismatch("value", out_data.value, want.value);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.lines_held !== want.lines_held)
            report_mismatch("lines_held", out_data.lines_held, want.lines_held);
        end
      end
    end
  end

endmodule

/* dv/tb_monotone_lower_envelope_core.sv */
`timescale 1ns / 1ps
module tb_monotone_lower_envelope_core;
  import mle_pkg::*;

  localparam int     DEPTH       = STACK_DEPTH_DEF;
  localparam int     RANDOM_ITEMS = 640;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam longint S32_MIN     = -(longint'(1) << 31);
  // func code with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int     fail_count;
  int     pending;
  int     results_seen;
  int     send_idle_pct;
  int     recv_idle_pct;
  longint cycle_count = 0;
  // slope of the last line pushed by the random sequence; keeps inserts decreasing
  longint last_slope;

  monotone_lower_envelope_core #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  envelope_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver backpressure, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // one transfer on the item channel; valid stays up between back-to-back items
  task automatic send_item(logic [FUNC_W-1:0] f, longint s, longint c, longint x);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.func = f;
    in_data.line_slope = SLOPE_W'(s);
    in_data.line_intercept = c;
    in_data.query_x = X_W'(x);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic query(longint x);
    send_item(FUNC_QUERY, $urandom, {$urandom, $urandom}, x);
  endtask

  task automatic insert(longint s, longint c);
    send_item(FUNC_INSERT, s, c, $urandom);
  endtask

  task automatic clear_hull();
    send_item(FUNC_CLEAR, $urandom, {$urandom, $urandom}, $urandom);
    last_slope = 0;
  endtask

  // let every result drain; every item answers, so a short pause is enough
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write, only issued while the block is drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_sentinel(longint s, longint c);
    write_reg(CFG_SENT_SLOPE, {{32{s[31]}}, s[31:0]});
    write_reg(CFG_SENT_ICPT, c);
  endtask

  // mostly well-formed decreasing inserts and queries, plus clears and noise
  task automatic random_phase(int n);
    int     roll;
    longint s;
    longint c;
    clear_hull();
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        if ($urandom_range(1)) query($signed($urandom_range(4000)) - 2000);
        else query($signed($urandom));
      end else if (roll < 87) begin
        roll = $urandom_range(9);
        if (roll < 5) s = last_slope - $urandom_range(8, 1);
        else if (roll < 8) s = last_slope - $urandom_range(1000, 1);
        else s = last_slope - $urandom_range(1 << 20, 1);
        if (s < S32_MIN) begin
          clear_hull();
          continue;
        end
        if ($urandom_range(1)) c = {$urandom, $urandom};
        else c = $signed($urandom_range(2000000)) - 1000000;
        insert(s, c);
        last_slope = s;
      end else if (roll < 92) begin
        clear_hull();
      end else if (roll < 97) begin
        // broken sequence: arbitrary slope, often rejected or popping deep
        insert($signed($urandom), {$urandom, $urandom});
      end else begin
        send_item(FUNC_SPARE, $urandom, {$urandom, $urandom}, $urandom);
        i--;
      end
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SENT_SLOPE;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    last_slope = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset hull, field extremes, every operation, slope rejects
    send_idle_pct = 20;
    recv_idle_pct = 20;
    query(0);
    query(S32_MIN);
    query(2147483647);
    insert(2147483647, 0);                       // slope above top, rejected
    insert(0, 5);                                // equal slope, rejected
    insert(-1, 64'h7fff_ffff_ffff_ffff);
    insert(-2, 64'h8000_0000_0000_0000);         // pops the two lines before it
    insert(S32_MIN, 64'h8000_0000_0000_0000);
    query(2147483647);
    query(S32_MIN);
    query(1);
    send_item(FUNC_SPARE, -1, -1, -1);           // unused code is ignored
    clear_hull();
    insert(-3, 100);
    query(-7);
    insert(-5, -1);
    query(50);
    drain();

    // parallel sentinel: zero slope, intercept above then below the zero line
    set_sentinel(0, 5);
    clear_hull();
    query(-3);
    query(3);
    insert(-1, 2);
    query(0);
    drain();
    set_sentinel(0, -5);
    clear_hull();
    query(-3);
    query(3);
    drain();
    // sentinel slope above an inserted line that pops to the bottom, then a slope reject
    set_sentinel(-5, 10);
    clear_hull();
    insert(-7, -100);
    insert(-5 - 1, 64'h8000_0000_0000_0000);
    query(0);
    drain();

    // fill the stack with a convex chain, then one insert too many
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_sentinel(1000000000, 0);
    clear_hull();
    for (longint j = 2; j <= DEPTH; j++) insert(-(j - 1), (j - 1) * (j - 1));
    query(100000);
    query(-5);
    insert(-2000, -longint'(1) << 40);          // steep deep line pops nearly all
    query(7);
    drain();

    // random phases under the three idle patterns and changing sentinels
    send_idle_pct = 34;
    recv_idle_pct = 82;
    set_sentinel(S32_MIN, 64'h8000_0000_0000_0000);
    random_phase(RANDOM_ITEMS / 3);
    send_idle_pct = 82;
    recv_idle_pct = 34;
    set_sentinel(2147483647, 64'h7fff_ffff_ffff_ffff);
    random_phase(RANDOM_ITEMS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_sentinel($signed($urandom), {$urandom, $urandom});
    random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    $display("covered queries, inserts, clears, rejects, a full stack and parallel lines");
    $display("%0d results checked over %0d cycles", results_seen, cycle_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
